FILE: hdl/csb_pkg.sv
// ----------------------------------------------------------------------------
// csb_pkg
// shared types and codes for the cursor sequence buffer
// ----------------------------------------------------------------------------
package csb_pkg;

	// request codes
	localparam logic [2:0] REQ_START   = 3'd0;
	localparam logic [2:0] REQ_ADVANCE = 3'd1;
	localparam logic [2:0] REQ_INSERT  = 3'd2;
	localparam logic [2:0] REQ_ATTACH  = 3'd3;
	localparam logic [2:0] REQ_REMOVE  = 3'd4;

	// error codes
	localparam logic [1:0] ERR_NONE       = 2'd0;
	localparam logic [1:0] ERR_FULL       = 2'd1;
	localparam logic [1:0] ERR_NO_CURRENT = 2'd2;

	typedef struct packed {
		logic [2:0]  req_type;
		logic [31:0] entry_value;
	} csb_req_t;

	typedef struct packed {
		logic [31:0] current_value;
		logic        has_current;
		logic [5:0]  entry_count;
		logic [5:0]  cursor_position;
		logic [1:0]  error_code;
	} csb_rsp_t;

	typedef enum logic [5:0] {
		S_IDLE = 6'b000001,
		S_UP   = 6'b000010,
		S_PUT  = 6'b000100,
		S_DOWN = 6'b001000,
		S_READ = 6'b010000,
		S_DONE = 6'b100000
	} csb_state_t;

endpackage

FILE: hdl/csb_ram.sv
// ----------------------------------------------------------------------------
// csb_ram
// entry store: one write port, one read port with registered data
// ----------------------------------------------------------------------------
module csb_ram #(
	parameter int DEPTH = 32,
	parameter int WIDTH = 32,
	parameter int AW    = 5
) (
	input  logic             clk,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  logic [WIDTH-1:0] wr_data,
	input  logic             rd_en,
	input  logic [AW-1:0]    rd_addr,
	output logic [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// read data holds until the next read
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

FILE: hdl/cursor_sequence_buffer.sv
// ----------------------------------------------------------------------------
// cursor_sequence_buffer
// ordered list of words in a fixed store, with an entry count and a cursor;
// start, advance, insert before, attach after and remove current
// ----------------------------------------------------------------------------
//
//  channel  direction  payload    handshake
//  req      in         csb_req_t  req_valid / req_stall
//  rsp      out        csb_rsp_t  rsp_valid / rsp_stall
//
// one request at a time; req_stall stays high from the transfer until the result is loaded
// start, advance, unknown and error cases go from the read state to the done state;
// insert and attach pass the shift-up loop and the put state first, remove the
// shift-down loop, where the loops shift up to STORE_DEPTH-1 entries
// the shift loop moves one entry per cycle through the single store port pair
// reset clears count, cursor and handshake state; the store needs no clearing
// a waiting result in the output register does not block the next transfer in
//
module cursor_sequence_buffer
	import csb_pkg::*;
#(
	parameter int STORE_DEPTH = 32,
	parameter int WORD_BITS   = 32
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     req_valid,
	output logic     req_stall,
	input  csb_req_t req,
	output logic     rsp_valid,
	input  logic     rsp_stall,
	output csb_rsp_t rsp
);

	localparam int AW    = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
	localparam int CNT_W = $clog2(STORE_DEPTH + 1);
	localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(STORE_DEPTH);

	// control state
	csb_state_t       state_q, state_n;
	logic [CNT_W-1:0] count_q, count_n;
	logic [CNT_W-1:0] cur_q, cur_n;
	logic             pend_q, pend_n;
	logic             rsp_valid_q;

	// working registers of the shift loop
	logic [CNT_W-1:0] k_q, k_n;
	logic [CNT_W-1:0] bound_q, bound_n;
	logic [AW-1:0]    wa_q, wa_n;
	logic [WORD_BITS-1:0] word_q;
	logic [1:0]       err_q, err_n;
	csb_rsp_t         rsp_q;

	// store ports
	logic                 wr_en, rd_en;
	logic [AW-1:0]        wr_addr, rd_addr;
	logic [WORD_BITS-1:0] wr_data, rd_data;

	logic                 req_xfer, rsp_load;
	logic                 cur_ok;
	logic                 full;
	logic [CNT_W-1:0]     km1;
	logic [CNT_W-1:0]     pos;
	logic [WORD_BITS+31:0] win_ext;
	logic [WORD_BITS-1:0]  word_in;
	logic [WORD_BITS+31:0] rd_ext;
	logic [CNT_W+5:0]      cnt_ext;
	logic [CNT_W+5:0]      cur_ext;

	csb_ram #(
		.DEPTH (STORE_DEPTH),
		.WIDTH (WORD_BITS),
		.AW    (AW)
	) u_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	assign req_stall = (state_q != S_IDLE);
	assign req_xfer  = req_valid && !req_stall;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// result leaves the done state once the output register is free
	assign rsp_load = (state_q == S_DONE) && (!rsp_valid_q || !rsp_stall);

	assign cur_ok = (cur_q < count_q);
	assign full   = (count_q == DEPTH_C);
	assign km1    = k_q - 1'b1;

	// keep the low WORD_BITS of the incoming word
	assign win_ext = {{WORD_BITS{1'b0}}, req.entry_value};
	assign word_in = win_ext[WORD_BITS-1:0];

	assign rd_ext  = {32'd0, rd_data};
	assign cnt_ext = {6'd0, count_q};
	assign cur_ext = {6'd0, cur_q};

	// store port control
	always_comb begin
		rd_en   = 1'b0;
		rd_addr = cur_q[AW-1:0];
		wr_en   = pend_q;
		wr_addr = wa_q;
		wr_data = rd_data;
		unique case (state_q)
			S_UP: begin
				// read k-1, written to k in the next cycle
				rd_en   = (k_q > bound_q);
				rd_addr = km1[AW-1:0];
			end
			S_DOWN: begin
				// read k, written to k-1 in the next cycle
				rd_en   = (k_q < bound_q);
				rd_addr = k_q[AW-1:0];
			end
			S_PUT: begin
				wr_en   = 1'b1;
				wr_addr = bound_q[AW-1:0];
				wr_data = word_q;
			end
			S_READ: begin
				rd_en = cur_ok;
			end
			default: begin
			end
		endcase
	end

	// sequencer
	always_comb begin
		state_n = state_q;
		count_n = count_q;
		cur_n   = cur_q;
		k_n     = k_q;
		bound_n = bound_q;
		err_n   = err_q;
		pend_n  = 1'b0;
		wa_n    = wa_q;
		pos     = '0;
		unique case (state_q)
			S_IDLE: begin
				if (req_xfer) begin
					err_n   = ERR_NONE;
					state_n = S_READ;
					unique case (req.req_type) inside
						REQ_START: begin
							cur_n = '0;
						end
						REQ_ADVANCE: begin
							if (cur_ok) begin
								cur_n = cur_q + 1'b1;
							end else begin
								err_n = ERR_NO_CURRENT;
							end
						end
						REQ_INSERT, REQ_ATTACH: begin
							if (full) begin
								err_n = ERR_FULL;
							end else begin
								// insert goes before the cursor or at the front,
								// attach after the cursor or at the end
								if (req.req_type == REQ_INSERT) begin
									pos = cur_ok ? cur_q : '0;
								end else begin
									pos = cur_ok ? (cur_q + 1'b1) : count_q;
								end
								k_n     = count_q;
								bound_n = pos;
								cur_n   = pos;
								count_n = count_q + 1'b1;
								state_n = S_UP;
							end
						end
						REQ_REMOVE: begin
							if (cur_ok) begin
								k_n     = cur_q + 1'b1;
								bound_n = count_q;
								count_n = count_q - 1'b1;
								state_n = S_DOWN;
							end else begin
								err_n = ERR_NO_CURRENT;
							end
						end
						default: begin
							// unknown request, nothing changes
						end
					endcase
				end
			end
			S_UP: begin
				pend_n = rd_en;
				if (rd_en) begin
					wa_n = k_q[AW-1:0];
					k_n  = km1;
				end else if (!pend_q) begin
					state_n = S_PUT;
				end
			end
			S_DOWN: begin
				pend_n = rd_en;
				if (rd_en) begin
					wa_n = km1[AW-1:0];
					k_n  = k_q + 1'b1;
				end else if (!pend_q) begin
					state_n = S_READ;
				end
			end
			S_PUT: begin
				state_n = S_READ;
			end
			S_READ: begin
				state_n = S_DONE;
			end
			S_DONE: begin
				if (rsp_load) begin
					state_n = S_IDLE;
				end
			end
			default: begin
				state_n = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			cur_q       <= '0;
			pend_q      <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_n;
			count_q <= count_n;
			cur_q   <= cur_n;
			pend_q  <= pend_n;
			if (rsp_load) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		k_q     <= k_n;
		bound_q <= bound_n;
		wa_q    <= wa_n;
		err_q   <= err_n;
		if (req_xfer) begin
			word_q <= word_in;
		end
		// result register, current word masked off when there is none
		if (rsp_load) begin
			rsp_q.current_value   <= cur_ok ? rd_ext[31:0] : 32'd0;
			rsp_q.has_current     <= cur_ok;
			rsp_q.entry_count     <= cnt_ext[5:0];
			rsp_q.cursor_position <= cur_ext[5:0];
			rsp_q.error_code      <= err_q;
		end
	end

endmodule
